FILE: rtl/pau_pkg.sv
// Shared types, codes and microcode ROM for the polynomial arithmetic unit.
package pau_pkg;

  localparam int unsigned RES_W   = 36;  // result coefficient width
  localparam int unsigned PWR_W   = 4;   // load power and degree register width
  localparam int unsigned RPWR_W  = 5;   // result power width
  localparam int unsigned IN_CW   = 16;  // input coefficient width
  localparam int unsigned CFG_IW  = 2;   // configuration index width
  localparam int unsigned CFG_DW  = 4;   // configuration data width

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DER = 2'd3
  } op_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_OPERATION = 2'd0,
    REG_DEGREE_A  = 2'd1,
    REG_DEGREE_B  = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_e;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_COMPUTE = 1'b1
  } mode_e;

  typedef enum logic {
    SEL_A = 1'b0,
    SEL_B = 1'b1
  } poly_sel_e;

  // Micro-program addresses.
  typedef enum logic [2:0] {
    U_IDLE = 3'd0,
    U_ADD  = 3'd1,
    U_SUB  = 3'd2,
    U_MUL  = 3'd3,
    U_MACC = 3'd4,
    U_DER  = 3'd5,
    U_DACC = 3'd6,
    U_EMIT = 3'd7
  } upc_e;

  // A store read address source: current power, inner index, power plus one.
  typedef enum logic [1:0] {
    ASEL_P  = 2'd0,
    ASEL_I  = 2'd1,
    ASEL_P1 = 2'd2,
    ASEL_NA = 2'd3
  } asel_e;

  // B store read address source: current power or power minus inner index.
  typedef enum logic {
    BSEL_P   = 1'b0,
    BSEL_PMI = 1'b1
  } bsel_e;

  // Second multiplier operand: B coefficient or power plus one.
  typedef enum logic {
    MULB_COEF = 1'b0,
    MULB_POW  = 1'b1
  } mulb_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_SUB  = 2'd2,
    ACC_PROD = 2'd3
  } acc_e;

  typedef enum logic [1:0] {
    J_FETCH = 2'd0,  // wait for an input transaction, dispatch on compute
    J_GOTO  = 2'd1,  // unconditional jump to target
    J_LOOP  = 2'd2,  // target when inner index passed degree A, else alt
    J_EMIT  = 2'd3   // wait for output slot, then next power or idle
  } jump_e;

  typedef struct packed {
    asel_e asel;
    bsel_e bsel;
    mulb_e mulb;
    logic  prod_en;
    acc_e  acc;
    logic  i_inc;
    jump_e jump;
    upc_e  target;
    upc_e  alt;
  } ucw_t;

  function automatic ucw_t ucode_rom(upc_e addr);
    ucw_t w;
    w = '{asel: ASEL_P, bsel: BSEL_P, mulb: MULB_COEF, prod_en: 1'b0, acc: ACC_HOLD,
          i_inc: 1'b0, jump: J_GOTO, target: U_IDLE, alt: U_IDLE};
    case (addr)
      U_IDLE: begin
        w.jump = J_FETCH;
      end
      U_ADD: begin
        w.acc    = ACC_ADD;
        w.target = U_EMIT;
      end
      U_SUB: begin
        w.acc    = ACC_SUB;
        w.target = U_EMIT;
      end
      U_MUL: begin
        w.asel    = ASEL_I;
        w.bsel    = BSEL_PMI;
        w.prod_en = 1'b1;
        w.i_inc   = 1'b1;
        w.target  = U_MACC;
      end
      U_MACC: begin
        w.acc    = ACC_PROD;
        w.jump   = J_LOOP;
        w.target = U_EMIT;
        w.alt    = U_MUL;
      end
      U_DER: begin
        w.asel    = ASEL_P1;
        w.mulb    = MULB_POW;
        w.prod_en = 1'b1;
        w.target  = U_DACC;
      end
      U_DACC: begin
        w.acc    = ACC_PROD;
        w.target = U_EMIT;
      end
      U_EMIT: begin
        w.jump = J_EMIT;
      end
      default: begin
        w.jump = J_FETCH;
      end
    endcase
    return w;
  endfunction

  // Entry point of the per-coefficient routine of each operation.
  function automatic upc_e op_entry(op_e op);
    upc_e a;
    case (op)
      OP_ADD:  a = U_ADD;
      OP_SUB:  a = U_SUB;
      OP_MUL:  a = U_MUL;
      OP_DER:  a = U_DER;
      default: a = U_ADD;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/pau_if.sv
// Handshake channel interfaces: input items, result items, configuration writes.
interface pau_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic                                   poly_select;
  logic [pau_pkg::PWR_W-1:0]              power;
  logic signed [pau_pkg::IN_CW-1:0]       coefficient;

  modport source (output valid, mode, poly_select, power, coefficient, input ready);
  modport sink   (input valid, mode, poly_select, power, coefficient, output ready);
endinterface

interface pau_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [pau_pkg::RPWR_W-1:0]             result_power;
  logic signed [pau_pkg::RES_W-1:0]       result_coefficient;
  logic                                   last;

  modport source (output valid, result_power, result_coefficient, last, input ready);
  modport sink   (input valid, result_power, result_coefficient, last, output ready);
endinterface

interface pau_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [pau_pkg::CFG_IW-1:0]             index;
  logic [pau_pkg::CFG_DW-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/polynomial_arithmetic_unit_top.sv
// Polynomial arithmetic unit: coefficient stores, microcoded sequencer and MAC datapath.
// Load transaction: taken in any idle cycle, one per cycle; the store is written at acceptance.
// Compute transaction: taken in the idle (fetch) state, then per result coefficient (highest power first)
//   add/subtract U_ADD/U_SUB, derivative U_DER then U_DACC, multiply U_MUL then U_MACC per A term,
//   each followed by U_EMIT on the single shared MAC; the sequencer waits only while the output register is full.
// Reset (rst_ni low, asynchronous) clears the stores, configuration, micro-PC and output valid.
module polynomial_arithmetic_unit_top #(
  parameter int unsigned MAX_DEGREE = 15,
  parameter int unsigned COEF_WIDTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  pau_in_if.sink    in_i,
  pau_out_if.source out_o,
  pau_cfg_if.sink   cfg_i
);

  localparam int unsigned DEPTH = MAX_DEGREE + 1;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Multiplier B side must also hold power plus one (up to 15) as a signed value.
  localparam int unsigned MW    = (COEF_WIDTH > 6) ? COEF_WIDTH : 6;
  localparam int unsigned PW    = COEF_WIDTH + MW;
  localparam int unsigned RW    = pau_pkg::RES_W;

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------------
  pau_pkg::op_e                 op_q;
  logic [pau_pkg::PWR_W-1:0]    degree_a_q, degree_b_q;
  logic                         cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= pau_pkg::OP_ADD;
      degree_a_q <= '0;
      degree_b_q <= '0;
    end else if (cfg_fire) begin
      case (pau_pkg::reg_idx_e'(cfg_i.index))
        pau_pkg::REG_OPERATION: op_q       <= pau_pkg::op_e'(cfg_i.data[1:0]);
        pau_pkg::REG_DEGREE_A:  degree_a_q <= cfg_i.data[pau_pkg::PWR_W-1:0];
        pau_pkg::REG_DEGREE_B:  degree_b_q <= cfg_i.data[pau_pkg::PWR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Clamp degrees to the store size.
  logic [pau_pkg::PWR_W-1:0] da, db;
  assign da = (5'(degree_a_q) > 5'(MAX_DEGREE)) ? pau_pkg::PWR_W'(MAX_DEGREE) : degree_a_q;
  assign db = (5'(degree_b_q) > 5'(MAX_DEGREE)) ? pau_pkg::PWR_W'(MAX_DEGREE) : degree_b_q;

  // Highest result power of the configured operation.
  logic [pau_pkg::RPWR_W-1:0] top;
  always_comb begin
    case (op_q)
      pau_pkg::OP_ADD,
      pau_pkg::OP_SUB: top = (da > db) ? 5'(da) : 5'(db);
      pau_pkg::OP_MUL: top = 5'(da) + 5'(db);
      pau_pkg::OP_DER: top = (da != '0) ? 5'(da) - 5'd1 : 5'd0;
      default:         top = 5'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers.
  // ---------------------------------------------------------------------------
  pau_pkg::upc_e               upc_q, upc_d;
  pau_pkg::ucw_t               uw;
  logic [pau_pkg::RPWR_W-1:0]  p_q, p_d;      // power being produced
  logic [pau_pkg::RPWR_W-1:0]  i_q, i_d;      // convolution index into A
  logic signed [RW-1:0]        acc_q, acc_d;
  logic signed [RW-1:0]        prod_q, prod_d;

  logic                        out_valid_q, out_valid_d;
  logic [pau_pkg::RPWR_W-1:0]  out_power_q, out_power_d;
  logic signed [RW-1:0]        out_coef_q, out_coef_d;
  logic                        out_last_q, out_last_d;

  assign uw = pau_pkg::ucode_rom(upc_q);

  logic in_fire, out_free, emit;
  assign in_i.ready = (upc_q == pau_pkg::U_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;
  assign emit       = (uw.jump == pau_pkg::J_EMIT) & out_free;

  // ---------------------------------------------------------------------------
  // Coefficient stores: flops, cleared by reset, one read port each.
  // ---------------------------------------------------------------------------
  logic signed [COEF_WIDTH-1:0] store_a_q [DEPTH];
  logic signed [COEF_WIDTH-1:0] store_b_q [DEPTH];
  logic                         load_ok;
  logic [IW-1:0]                wr_idx;
  logic signed [COEF_WIDTH-1:0] ld_coef;

  assign load_ok = {1'b0, in_i.power} <= 5'(MAX_DEGREE);
  assign wr_idx  = IW'(in_i.power);
  // Take the low COEF_WIDTH bits of the 16-bit field; wider stores zero-extend it.
  assign ld_coef = COEF_WIDTH'($unsigned(in_i.coefficient));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        store_a_q[k] <= '0;
        store_b_q[k] <= '0;
      end
    end else if (in_fire && (in_i.mode == pau_pkg::MODE_LOAD) && load_ok) begin
      if (in_i.poly_select == pau_pkg::SEL_A) begin
        store_a_q[wr_idx] <= ld_coef;
      end else begin
        store_b_q[wr_idx] <= ld_coef;
      end
    end
  end

  // Read address selection; terms outside a polynomial's degree read as zero.
  logic [pau_pkg::RPWR_W-1:0]   a_addr, b_addr, p_plus1;
  logic                         a_in, b_in;
  logic signed [COEF_WIDTH-1:0] a_t, b_t;

  assign p_plus1 = p_q + 5'd1;

  always_comb begin
    case (uw.asel)
      pau_pkg::ASEL_P:  a_addr = p_q;
      pau_pkg::ASEL_I:  a_addr = i_q;
      pau_pkg::ASEL_P1: a_addr = p_plus1;
      default:          a_addr = p_q;
    endcase
    a_in = a_addr <= 5'(da);
    if (uw.bsel == pau_pkg::BSEL_PMI) begin
      b_addr = p_q - i_q;
      b_in   = (p_q >= i_q) && (b_addr <= 5'(db));
    end else begin
      b_addr = p_q;
      b_in   = p_q <= 5'(db);
    end
  end

  assign a_t = a_in ? store_a_q[IW'(a_addr)] : '0;
  assign b_t = b_in ? store_b_q[IW'(b_addr)] : '0;

  // Shared multiplier; the product is cast to the 36-bit result width.
  logic signed [COEF_WIDTH-1:0] mul_a;
  logic signed [MW-1:0]         mul_b;
  logic signed [PW-1:0]         mul_full;

  assign mul_a    = a_t;
  assign mul_b    = (uw.mulb == pau_pkg::MULB_POW) ? MW'($signed({1'b0, p_plus1}))
                                                   : MW'(b_t);
  assign mul_full = PW'(mul_a) * PW'(mul_b);

  // ---------------------------------------------------------------------------
  // Micro-sequencer: execute the control word, then follow its jump.
  // ---------------------------------------------------------------------------
  always_comb begin
    upc_d       = upc_q;
    p_d         = p_q;
    i_d         = i_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_power_d = out_power_q;
    out_coef_d  = out_coef_q;
    out_last_d  = out_last_q;

    if (uw.i_inc) begin
      i_d = i_q + 5'd1;
    end
    if (uw.prod_en) begin
      prod_d = RW'(mul_full);
    end
    case (uw.acc)
      pau_pkg::ACC_ADD:  acc_d = RW'(a_t) + RW'(b_t);
      pau_pkg::ACC_SUB:  acc_d = RW'(a_t) - RW'(b_t);
      pau_pkg::ACC_PROD: acc_d = acc_q + prod_q;
      default:           acc_d = acc_q;
    endcase

    case (uw.jump)
      pau_pkg::J_FETCH: begin
        // Start a run on a compute transaction; loads are handled by the stores.
        if (in_fire && (in_i.mode == pau_pkg::MODE_COMPUTE)) begin
          p_d   = top;
          i_d   = '0;
          acc_d = '0;
          upc_d = pau_pkg::op_entry(op_q);
        end
      end
      pau_pkg::J_GOTO: begin
        upc_d = uw.target;
      end
      pau_pkg::J_LOOP: begin
        upc_d = (i_q > 5'(da)) ? uw.target : uw.alt;
      end
      pau_pkg::J_EMIT: begin
        // Hold until the output register frees up, then advance to the next power, or to idle after power zero.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_power_d = p_q;
          out_coef_d  = acc_q;
          out_last_d  = (p_q == '0);
          if (p_q == '0) begin
            upc_d = pau_pkg::U_IDLE;
          end else begin
            p_d   = p_q - 5'd1;
            i_d   = '0;
            acc_d = '0;
            upc_d = pau_pkg::op_entry(op_q);
          end
        end
      end
      default: begin
        upc_d = pau_pkg::U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= pau_pkg::U_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    i_q         <= i_d;
    acc_q       <= acc_d;
    prod_q      <= prod_d;
    out_power_q <= out_power_d;
    out_coef_q  <= out_coef_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.result_power       = out_power_q;
  assign out_o.result_coefficient = out_coef_q;
  assign out_o.last               = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_at_power_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_power_q == '0)))
    else $error("last flag does not match power zero");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (p_q == '0)) |=> (upc_q == pau_pkg::U_IDLE))
    else $error("sequencer did not return to idle after last coefficient");

  a_mac_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == pau_pkg::U_MACC) |-> (i_q <= 5'(da) + 5'd1))
    else $error("convolution index ran past degree A");

  a_emit_not_blocked_twice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (p_q != '0)) |=> (upc_q != pau_pkg::U_IDLE && upc_q != pau_pkg::U_EMIT))
    else $error("sequencer skipped the next coefficient routine");

endmodule
